FILE: design/aled_pkg.sv
// Shared types and constants for the addressable LED PWM frame encoder.
`default_nettype none

package aled_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_APPLY = 2'd3
  } cmd_e;

  localparam logic [1:0] REG_LED_COUNT  = 2'd0;
  localparam logic [1:0] REG_ONE_DUTY   = 2'd1;
  localparam logic [1:0] REG_ZERO_DUTY  = 2'd2;
  localparam logic [1:0] REG_TAIL_SLOTS = 2'd3;

  localparam logic [4:0] LED_COUNT_RST  = 5'd11;
  localparam logic [7:0] ONE_DUTY_RST   = 8'd33;
  localparam logic [7:0] ZERO_DUTY_RST  = 8'd16;
  localparam logic [7:0] TAIL_SLOTS_RST = 8'd60;

  localparam int unsigned ColorW = 24;
  // bits go out MSB first: green 23..16, red 15..8, blue 7..0
  localparam logic [4:0] TOP_BIT = 5'd23;

  typedef struct packed {
    logic       sending;
    logic       last;
    logic       is_color;
    logic [4:0] bit_idx;
    logic [7:0] one_duty;
    logic [7:0] zero_duty;
  } slot_t;

endpackage

`default_nettype wire

FILE: design/aled_cmem.sv
// Two-bank color memory with per-entry bank map, frame snapshot and erase flags.
`default_nettype none

module aled_cmem #(
  parameter int unsigned MAX_LEDS = 16,
  parameter int unsigned LW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [LW-1:0] wr_idx_i,
  input  wire logic [23:0]   wr_data_i,
  input  wire logic          erase_i,
  input  wire logic          snap_i,
  input  wire logic          active_i,
  input  wire logic          rd_en_i,
  input  wire logic [LW-1:0] rd_idx_i,
  output logic      [23:0]   rd_data_o
);
  import aled_pkg::*;

  localparam int unsigned Depth = 2 ** (LW + 1);

  logic [ColorW-1:0]   mem_q [Depth];
  logic [MAX_LEDS-1:0] cur_q, cur_d;   // bank holding the live color
  logic [MAX_LEDS-1:0] shd_q, shd_d;   // bank holding the frame copy
  logic [MAX_LEDS-1:0] vld_q, vld_d;   // live entry written since erase
  logic [MAX_LEDS-1:0] svld_q, svld_d; // frame copy of vld_q
  logic [ColorW-1:0]   rd_q;
  logic                rd_vld_q;
  logic                wr_bank;

  // during a frame never overwrite the bank the frame is reading
  assign wr_bank = (active_i && (cur_q[wr_idx_i] == shd_q[wr_idx_i])) ?
                   ~cur_q[wr_idx_i] : cur_q[wr_idx_i];

  always_comb begin
    cur_d  = cur_q;
    shd_d  = shd_q;
    vld_d  = vld_q;
    svld_d = svld_q;
    if (erase_i) begin
      vld_d = '0;
    end
    if (wr_en_i) begin
      cur_d[wr_idx_i] = wr_bank;
      vld_d[wr_idx_i] = 1'b1;
    end
    if (snap_i) begin
      shd_d  = cur_q;
      svld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      shd_q    <= '0;
      vld_q    <= '0;
      svld_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      shd_q  <= shd_d;
      vld_q  <= vld_d;
      svld_q <= svld_d;
      if (rd_en_i) begin
        rd_vld_q <= svld_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[{wr_bank, wr_idx_i}] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[{shd_q[rd_idx_i], rd_idx_i}];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: design/aled_seq.sv
// Frame sequencer: walks LEDs and bit slots, then the tail slots.
`default_nettype none

module aled_seq #(
  parameter int unsigned LW = 4,
  parameter int unsigned CW = 5
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [CW-1:0]  eff_count_i,
  input  wire logic [7:0]     tail_slots_i,
  input  wire logic [7:0]     one_duty_i,
  input  wire logic [7:0]     zero_duty_i,
  input  wire logic           apply_i,
  input  wire logic           tick_i,
  output logic                start_o,
  output logic                active_o,
  output logic      [LW-1:0]  led_o,
  output aled_pkg::slot_t     slot_o
);
  import aled_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_COLOR = 3'b010,
    ST_TAIL  = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] led_q, led_d;
  logic [4:0]    bit_q, bit_d;
  logic [7:0]    tcnt_q, tcnt_d;
  logic [CW-1:0] frm_leds_q, frm_leds_d;
  logic [7:0]    frm_tail_q, frm_tail_d;
  logic [7:0]    frm_one_q, frm_one_d;
  logic [7:0]    frm_zero_q, frm_zero_d;
  logic          last_led, tail_last, no_tail;

  assign last_led  = (CW'(led_q) + CW'(1)) == frm_leds_q;
  assign no_tail   = (frm_tail_q == 8'd0);
  assign tail_last = ({1'b0, tcnt_q} + 9'd1) == {1'b0, frm_tail_q};
  assign active_o  = (state_q != ST_IDLE);
  assign start_o   = apply_i && (state_q == ST_IDLE) &&
                     ((eff_count_i != '0) || (tail_slots_i != 8'd0));
  assign led_o     = led_q;

  always_comb begin
    state_d    = state_q;
    led_d      = led_q;
    bit_d      = bit_q;
    tcnt_d     = tcnt_q;
    frm_leds_d = frm_leds_q;
    frm_tail_d = frm_tail_q;
    frm_one_d  = frm_one_q;
    frm_zero_d = frm_zero_q;
    slot_o           = '0;
    slot_o.bit_idx   = bit_q;
    slot_o.one_duty  = frm_one_q;
    slot_o.zero_duty = frm_zero_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_o) begin
          frm_leds_d = eff_count_i;
          frm_tail_d = tail_slots_i;
          frm_one_d  = one_duty_i;
          frm_zero_d = zero_duty_i;
          led_d      = '0;
          bit_d      = TOP_BIT;
          tcnt_d     = 8'd0;
          state_d    = (eff_count_i != '0) ? ST_COLOR : ST_TAIL;
        end
      end
      ST_COLOR: begin
        slot_o.sending  = 1'b1;
        slot_o.is_color = 1'b1;
        slot_o.last     = last_led && (bit_q == 5'd0) && no_tail;
        if (tick_i) begin
          if (bit_q == 5'd0) begin
            bit_d = TOP_BIT;
            if (last_led) begin
              led_d   = '0;
              tcnt_d  = 8'd0;
              state_d = no_tail ? ST_IDLE : ST_TAIL;
            end else begin
              led_d = led_q + LW'(1);
            end
          end else begin
            bit_d = bit_q - 5'd1;
          end
        end
      end
      ST_TAIL: begin
        slot_o.sending = 1'b1;
        slot_o.last    = tail_last;
        if (tick_i) begin
          if (tail_last) begin
            state_d = ST_IDLE;
          end else begin
            tcnt_d = tcnt_q + 8'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      led_q      <= '0;
      bit_q      <= TOP_BIT;
      tcnt_q     <= 8'd0;
      frm_leds_q <= '0;
      frm_tail_q <= 8'd0;
      frm_one_q  <= 8'd0;
      frm_zero_q <= 8'd0;
    end else begin
      state_q    <= state_d;
      led_q      <= led_d;
      bit_q      <= bit_d;
      tcnt_q     <= tcnt_d;
      frm_leds_q <= frm_leds_d;
      frm_tail_q <= frm_tail_d;
      frm_one_q  <= frm_one_d;
      frm_zero_q <= frm_zero_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/addressable_led_pwm_frame_encoder.sv
// A tick word's result passes the memory read (stage 1) and then the output register.
// Throughput: one input word per cycle while the output is not stalled;
// set, erase and apply give no result word. Color ticks use the memory's single read port.
// Reset: colors read as dark through per-entry valid flags, so no clearing pass is needed;
// registers return to their defaults and the encoder is idle.
`default_nettype none

module addressable_led_pwm_frame_encoder #(
  parameter int unsigned MAX_LEDS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] command_i,
  input  wire logic [3:0] led_index_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] duty_o,
  output logic            sending_o,
  output logic            frame_last_o
);
  import aled_pkg::*;

  localparam int unsigned LW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CW = $clog2(MAX_LEDS + 1);

  logic [4:0]    led_count_q;
  logic [7:0]    one_duty_q, zero_duty_q, tail_slots_q;
  logic [CW-1:0] eff_count;
  cmd_e          cmd;
  logic          in_acc, tick_acc, set_acc, erase_acc, apply_acc, wr_en;
  logic          start, active;
  logic [LW-1:0] led;
  slot_t         slot, s1_slot_q;
  logic          s1_v_q, s1_adv;
  logic [23:0]   rd_data;
  logic [7:0]    duty_d;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q  <= LED_COUNT_RST;
      one_duty_q   <= ONE_DUTY_RST;
      zero_duty_q  <= ZERO_DUTY_RST;
      tail_slots_q <= TAIL_SLOTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LED_COUNT:  led_count_q  <= cfg_data_i[4:0];
        REG_ONE_DUTY:   one_duty_q   <= cfg_data_i;
        REG_ZERO_DUTY:  zero_duty_q  <= cfg_data_i;
        REG_TAIL_SLOTS: tail_slots_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_count = (32'(led_count_q) > 32'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(led_count_q);

  assign cmd       = cmd_e'(command_i);
  assign in_acc    = in_valid_i && in_ready_o;
  assign tick_acc  = in_acc && (cmd == CMD_TICK);
  assign set_acc   = in_acc && (cmd == CMD_SET);
  assign erase_acc = in_acc && (cmd == CMD_ERASE);
  assign apply_acc = in_acc && (cmd == CMD_APPLY);
  assign wr_en     = set_acc && (32'(led_index_i) < 32'(eff_count));

  aled_seq #(.LW(LW), .CW(CW)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .eff_count_i  (eff_count),
    .tail_slots_i (tail_slots_q),
    .one_duty_i   (one_duty_q),
    .zero_duty_i  (zero_duty_q),
    .apply_i      (apply_acc),
    .tick_i       (tick_acc),
    .start_o      (start),
    .active_o     (active),
    .led_o        (led),
    .slot_o       (slot)
  );

  aled_cmem #(.MAX_LEDS(MAX_LEDS), .LW(LW)) u_cmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (LW'(led_index_i)),
    .wr_data_i ({green_i, red_i, blue_i}),
    .erase_i   (erase_acc),
    .snap_i    (start),
    .active_i  (active),
    .rd_en_i   (tick_acc && slot.is_color),
    .rd_idx_i  (led),
    .rd_data_o (rd_data)
  );

  // stage 1 waits on the memory read; read data holds while it stalls
  assign s1_adv     = s1_v_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;

  assign duty_d = !s1_slot_q.is_color ? 8'd0 :
                  rd_data[s1_slot_q.bit_idx] ? s1_slot_q.one_duty : s1_slot_q.zero_duty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (tick_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_slot_q <= slot;
    end
    if (s1_adv) begin
      duty_o       <= duty_d;
      sending_o    <= s1_slot_q.sending;
      frame_last_o <= s1_slot_q.last;
    end
  end

endmodule

`default_nettype wire

FILE: design/aled_chk.sv
// Port-level checker for the frame encoder and its bind.
`default_nettype none

module aled_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] duty_o,
  input wire logic       sending_o,
  input wire logic       frame_last_o
);

  // the only back-pressure source is a full, stalled output
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a stalled output word");

  a_last_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> sending_o)
    else $error("frame end marked on an idle slot");

  a_idle_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sending_o) |-> (duty_o == 8'd0))
    else $error("nonzero duty on an idle slot");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(duty_o) && $stable(sending_o) && $stable(frame_last_o)))
    else $error("output word changed while stalled");

endmodule

bind addressable_led_pwm_frame_encoder aled_chk u_aled_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .duty_o       (duty_o),
  .sending_o    (sending_o),
  .frame_last_o (frame_last_o)
);

`default_nettype wire
